/* rtl/sdlc_pkg.sv */
// ----------------------------------------------------------------------------
// sdlc_pkg
// Shared types and constants of the SDLC transmit framer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdlc_pkg;

	localparam int DATA_W   = 8;
	localparam int CRC_BITS = 16;
	localparam int CNT_W    = 4;
	localparam int RUN_W    = 3;

	typedef logic [DATA_W-1:0]   data_t;
	typedef logic [CRC_BITS-1:0] crc_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [RUN_W-1:0]    run_t;

	localparam crc_t  CRC_INIT  = 16'hFFFF;
	localparam crc_t  CRC_TAPS  = crc_t'((1 << 5) + (1 << 12));
	localparam run_t  STUFF_RUN = 3'd5;
	localparam data_t FLAG_BITS = 8'b0111_1110;

endpackage

`default_nettype wire

/* rtl/sdlc_byte_if.sv */
// ----------------------------------------------------------------------------
// sdlc_byte_if
// Payload byte channel: valid/ready handshake carrying one frame byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdlc_byte_if;

	logic           valid;
	logic           ready;
	sdlc_pkg::data_t data_byte;
	logic           frame_last;

	modport source (output valid, output data_byte, output frame_last, input ready);
	modport sink (input valid, input data_byte, input frame_last, output ready);

endinterface

`default_nettype wire

/* rtl/sdlc_bit_if.sv */
// ----------------------------------------------------------------------------
// sdlc_bit_if
// Line bit channel: valid/ready handshake carrying one serial line bit.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdlc_bit_if;

	logic valid;
	logic ready;
	logic tx_bit;
	logic run_last;
	logic frame_end;

	modport source (output valid, output tx_bit, output run_last, output frame_end,
		input ready);
	modport sink (input valid, input tx_bit, input run_last, input frame_end,
		output ready);

endinterface

`default_nettype wire

/* rtl/sdlc_transmit_framer_core.sv */
// ----------------------------------------------------------------------------
// sdlc_transmit_framer_core
// Bit-serial SDLC transmit framer: opening flag, LSB-first data with CRC-16,
// inverted CRC, closing flag, zero insertion after five ones.
// ----------------------------------------------------------------------------
// Throughput: one line bit per cycle while bit_out.ready is high, with a gap
// at each byte accept; a mid-frame byte sends 8 to 10 line bits, plus 8 for
// the opening flag; a final byte adds 16 to 20 CRC/stuffed bits, 8 flag bits.
// A new byte is taken only once the previous one is fully shifted.
// After accept the sequencer leaves idle, then registers the first line bit.
// Reset at once idles the sequencer, presets the CRC, clears run and output.
// ----------------------------------------------------------------------------
`default_nettype none

module sdlc_transmit_framer_core (
	input  wire        clk,
	input  wire        arst_n,
	sdlc_byte_if.sink  byte_in,
	sdlc_bit_if.source bit_out
);

	import sdlc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_OFLAG = 3'd1;
	localparam logic [2:0] ST_DATA  = 3'd2;
	localparam logic [2:0] ST_CRC   = 3'd3;
	localparam logic [2:0] ST_CFLAG = 3'd4;
	localparam logic [2:0] ST_TAIL  = 3'd5;

	logic [2:0] state_q;
	cnt_t       cnt_q;
	data_t      data_q;
	logic       last_q;
	crc_t       crc_q;
	run_t       ones_q;
	logic       in_frame_q;

	logic       out_valid_q;
	logic       out_bit_q;
	logic       out_run_last_q;
	logic       out_frame_end_q;

	logic       accept;
	logic       advance;
	logic       stuff;
	logic       flag_bit;
	logic       fb;
	run_t       ones_next;

	assign byte_in.ready = (state_q == ST_IDLE);
	assign accept        = byte_in.valid && byte_in.ready;
	assign advance       = (state_q != ST_IDLE) && (!out_valid_q || bit_out.ready);
	assign stuff         = (ones_q == STUFF_RUN) &&
		((state_q == ST_DATA) || (state_q == ST_CRC) ||
		 (state_q == ST_CFLAG) || (state_q == ST_TAIL));
	assign flag_bit      = FLAG_BITS[cnt_q[2:0]];
	assign fb            = data_q[0] ^ crc_q[CRC_BITS-1];

	always_comb begin
		ones_next = '0;
		if (state_q == ST_DATA && data_q[0]) begin
			ones_next = ones_q + run_t'(1);
		end else if (state_q == ST_CRC && !crc_q[CRC_BITS-1]) begin
			ones_next = ones_q + run_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			crc_q           <= CRC_INIT;
			ones_q          <= '0;
			in_frame_q      <= 1'b0;
			last_q          <= 1'b0;
			out_valid_q     <= 1'b0;
			out_bit_q       <= 1'b0;
			out_run_last_q  <= 1'b0;
			out_frame_end_q <= 1'b0;
		end else begin
			if (accept) begin
				last_q <= byte_in.frame_last;
				cnt_q  <= '0;
				if (!in_frame_q) begin
					crc_q      <= CRC_INIT;
					ones_q     <= '0;
					in_frame_q <= 1'b1;
					state_q    <= ST_OFLAG;
				end else begin
					state_q <= ST_DATA;
				end
			end

			if (advance) begin
				out_valid_q     <= 1'b1;
				out_run_last_q  <= 1'b0;
				out_frame_end_q <= 1'b0;
				if (stuff) begin
					out_bit_q <= 1'b0;
					ones_q    <= '0;
					if (state_q == ST_TAIL) begin
						out_run_last_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end else begin
					case (state_q)
						ST_OFLAG: begin
							out_bit_q <= flag_bit;
							cnt_q     <= cnt_q + cnt_t'(1);
							if (cnt_q == cnt_t'(DATA_W-1)) begin
								cnt_q   <= '0;
								state_q <= ST_DATA;
							end
						end
						ST_DATA: begin
							out_bit_q <= data_q[0];
							ones_q    <= ones_next;
							crc_q     <= {crc_q[CRC_BITS-2:0], fb} ^ (fb ? CRC_TAPS : '0);
							cnt_q     <= cnt_q + cnt_t'(1);
							if (cnt_q == cnt_t'(DATA_W-1)) begin
								cnt_q <= '0;
								if (last_q) begin
									state_q <= ST_CRC;
								end else if (ones_next == STUFF_RUN) begin
									state_q <= ST_TAIL;
								end else begin
									out_run_last_q <= 1'b1;
									state_q        <= ST_IDLE;
								end
							end
						end
						ST_CRC: begin
							out_bit_q <= ~crc_q[CRC_BITS-1];
							ones_q    <= ones_next;
							crc_q     <= {crc_q[CRC_BITS-2:0], 1'b0};
							cnt_q     <= cnt_q + cnt_t'(1);
							if (cnt_q == cnt_t'(CRC_BITS-1)) begin
								cnt_q   <= '0;
								state_q <= ST_CFLAG;
							end
						end
						ST_CFLAG: begin
							out_bit_q <= flag_bit;
							cnt_q     <= cnt_q + cnt_t'(1);
							if (cnt_q == cnt_t'(DATA_W-1)) begin
								cnt_q           <= '0;
								out_run_last_q  <= 1'b1;
								out_frame_end_q <= 1'b1;
								crc_q           <= CRC_INIT;
								ones_q          <= '0;
								in_frame_q      <= 1'b0;
								state_q         <= ST_IDLE;
							end
						end
						default: begin
							out_bit_q <= 1'b0;
							state_q   <= ST_IDLE;
						end
					endcase
				end
			end else if (bit_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= byte_in.data_byte;
		end else if (advance && !stuff && state_q == ST_DATA) begin
			data_q <= {1'b0, data_q[DATA_W-1:1]};
		end
	end

	assign bit_out.valid     = out_valid_q;
	assign bit_out.tx_bit    = out_bit_q;
	assign bit_out.run_last  = out_run_last_q;
	assign bit_out.frame_end = out_frame_end_q;

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ones_q <= STUFF_RUN)
		else $error("run of ones beyond stuffing limit");

	a_idle_no_stuff: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> ones_q != STUFF_RUN)
		else $error("stuffed zero left pending at end of transaction");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_frame_end_q |-> out_run_last_q)
		else $error("closing flag end without transaction end");

	a_idle_outside_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> state_q == ST_IDLE)
		else $error("sequencer busy outside a frame");

	a_close_restores_crc: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_frame_q) |-> crc_q == CRC_INIT && ones_q == '0)
		else $error("frame closed without restoring CRC and run");

endmodule

`default_nettype wire
